// File: rtl/core/ntn_pkg.sv
package ntn_pkg;

  localparam int OUT_FRAC_BITS = 14;
  localparam int QW            = OUT_FRAC_BITS + 2;
  localparam int NW            = 31 + OUT_FRAC_BITS + 1;
  localparam int RW            = 33;
  localparam int SQ_STEPS      = 32;
  localparam int CAP           = ((2 ** OUT_FRAC_BITS) > 32767) ? 32767 : (2 ** OUT_FRAC_BITS);

  localparam logic [47:0] ROW0_RST = 48'h0000_0000_1000;
  localparam logic [47:0] ROW1_RST = 48'h0000_1000_0000;
  localparam logic [47:0] ROW2_RST = 48'h1000_0000_0000;

  typedef enum logic [1:0] {
    CFG_ROW0 = 2'd0,
    CFG_ROW1 = 2'd1,
    CFG_ROW2 = 2'd2,
    CFG_MODE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0][30:0] mag;
    logic [2:0]       neg;
    logic             zero;
    logic             fin;
  } vec_t;

  typedef struct packed {
    vec_t        v;
    logic [63:0] l;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [2:0][QW-1:0] nlow;
    logic [2:0][QW-1:0] q;
    logic [31:0]        r;
    logic [2:0]         neg;
    logic               zero;
    logic               fin;
  } dv_t;

endpackage

// File: rtl/core/normal_transform_normalize.sv
// Transforms a signed Q4.12 vector by the 3x3 matrix (or its transpose) and
// returns it scaled to unit length in Q1.14, with zero_length set and zeros
// returned for a null vector. Fully pipelined: one vector per cycle unless the
// output stalls; vectors pass the front stages, the 32-stage square root (one root
// bit per stage), divider set-up and the 16-stage restoring divider (one quotient
// bit per stage). A stall on the output freezes the whole pipeline. Matrix and mode
// registers are read at the first stage, so write them only while the pipeline is empty.
module normal_transform_normalize (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  input  logic               final_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] unit_x_o,
  output logic signed [15:0] unit_y_o,
  output logic signed [15:0] unit_z_o,
  output logic               zero_length_o,
  output logic               final_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i
);

  logic [2:0][47:0] row_q;
  logic             mode_q;
  logic             en;

  logic [6:0]                 fv_q;
  logic [ntn_pkg::SQ_STEPS:0] sv_q;
  logic [ntn_pkg::QW-1:0]     dvv_q;

  logic signed [2:0][2:0][31:0] prod_q;
  logic [1:0]                   fin_q;
  logic signed [2:0][32:0]      s_q;
  logic [2:0][31:0]             mag3_q;
  logic [2:0]                   neg3_q;
  logic [31:0]                  or_q;
  logic [2:0][31:0]             mag4_q;
  logic [2:0]                   neg4_q;
  logic [5:0]                   bl_q;
  logic [1:0]                   fin3_q;
  ntn_pkg::vec_t                v5_q;
  ntn_pkg::vec_t                v6_q;
  logic [2:0][61:0]             sqr_q;
  ntn_pkg::sq_t                 sq_q [ntn_pkg::SQ_STEPS+1];
  ntn_pkg::dv_t                 dv_q [ntn_pkg::QW+1];

  logic signed [15:0] unit_x_q, unit_y_q, unit_z_q;
  logic               zero_q, fin_out_q, out_valid_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ntn_pkg::ROW0_RST;
      row_q[1] <= ntn_pkg::ROW1_RST;
      row_q[2] <= ntn_pkg::ROW2_RST;
      mode_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ntn_pkg::CFG_ROW0: row_q[0] <= cfg_data_i;
        ntn_pkg::CFG_ROW1: row_q[1] <= cfg_data_i;
        ntn_pkg::CFG_ROW2: row_q[2] <= cfg_data_i;
        ntn_pkg::CFG_MODE: mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q        <= '0;
      sv_q        <= '0;
      dvv_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      fv_q        <= {fv_q[5:0], in_valid_i};
      sv_q        <= {sv_q[ntn_pkg::SQ_STEPS-1:0], fv_q[6]};
      dvv_q       <= {dvv_q[ntn_pkg::QW-2:0], sv_q[ntn_pkg::SQ_STEPS]};
      out_valid_q <= dvv_q[ntn_pkg::QW-1];
    end
  end

  // front: products, sums, magnitudes, bit length, alignment, squares
  logic signed [15:0] vin [3];
  logic signed [15:0] melm [3][3];
  logic [2:0][31:0]   mag_c;
  logic [5:0]         bl_c;
  ntn_pkg::vec_t      v5_c;
  logic [4:0]         shl;
  logic [31:0]        shv;
  logic [63:0]        lsum;

  always_comb begin
    vin[0] = vec_x_i;
    vin[1] = vec_y_i;
    vin[2] = vec_z_i;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        melm[k][i] = mode_q ? $signed(row_q[k][16*i +: 16]) : $signed(row_q[i][16*k +: 16]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = s_q[k][32] ? 32'(-s_q[k]) : s_q[k][31:0];
    end
    bl_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (or_q[i]) bl_c = 6'(i + 1);
    end
    shl     = 5'(6'd31 - bl_q);
    v5_c    = '0;
    v5_c.neg  = neg4_q;
    v5_c.zero = (bl_q == 6'd0);
    v5_c.fin  = fin3_q[1];
    for (int k = 0; k < 3; k++) begin
      shv = mag4_q[k] << shl;
      v5_c.mag[k] = (bl_q == 6'd32) ? mag4_q[k][31:1] : shv[30:0];
    end
    lsum = 64'(sqr_q[0]) + 64'(sqr_q[1]) + 64'(sqr_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[k][i] <= 32'(melm[k][i] * vin[i]);
        end
        s_q[k] <= 33'($signed(prod_q[k][0])) + 33'($signed(prod_q[k][1]))
                + 33'($signed(prod_q[k][2]));
        sqr_q[k] <= 62'(v5_q.mag[k]) * 62'(v5_q.mag[k]);
      end
      fin_q  <= {fin_q[0], final_in_i};
      mag3_q <= mag_c;
      for (int k = 0; k < 3; k++) neg3_q[k] <= s_q[k][32];
      or_q   <= mag_c[0] | mag_c[1] | mag_c[2];
      fin3_q <= {fin3_q[0], fin_q[1]};
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      bl_q   <= bl_c;
      v5_q   <= v5_c;
      v6_q   <= v5_q;
      sq_q[0].v    <= v6_q;
      sq_q[0].l    <= lsum;
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
    end
  end

  // square root, one root bit per stage
  for (genvar g = 0; g < ntn_pkg::SQ_STEPS; g++) begin : g_sqrt
    logic [34:0] rem_n, trial;
    logic        ge;
    always_comb begin
      rem_n = {sq_q[g].rem[32:0], sq_q[g].l[63:62]};
      trial = {1'b0, sq_q[g].root, 2'b01};
      ge    = (rem_n >= trial);
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[g+1].v    <= sq_q[g].v;
        sq_q[g+1].l    <= {sq_q[g].l[61:0], 2'b00};
        sq_q[g+1].rem  <= ge ? (rem_n - trial) : rem_n;
        sq_q[g+1].root <= {sq_q[g].root[30:0], ge};
      end
    end
  end

  // divider set-up: numerator = mag << frac + r/2
  ntn_pkg::dv_t dv0_c;
  logic [ntn_pkg::NW-1:0] num;
  always_comb begin
    dv0_c      = '0;
    dv0_c.r    = sq_q[ntn_pkg::SQ_STEPS].root;
    dv0_c.neg  = sq_q[ntn_pkg::SQ_STEPS].v.neg;
    dv0_c.zero = sq_q[ntn_pkg::SQ_STEPS].v.zero;
    dv0_c.fin  = sq_q[ntn_pkg::SQ_STEPS].v.fin;
    num        = '0;
    for (int k = 0; k < 3; k++) begin
      num = (ntn_pkg::NW'(sq_q[ntn_pkg::SQ_STEPS].v.mag[k]) << ntn_pkg::OUT_FRAC_BITS)
          + ntn_pkg::NW'(sq_q[ntn_pkg::SQ_STEPS].root[31:1]);
      dv0_c.rem[k]  = ntn_pkg::RW'(num[ntn_pkg::NW-1:ntn_pkg::QW]);
      dv0_c.nlow[k] = num[ntn_pkg::QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= dv0_c;
  end

  // restoring division, one quotient bit per stage
  for (genvar g = 0; g < ntn_pkg::QW; g++) begin : g_div
    ntn_pkg::dv_t nx;
    logic [ntn_pkg::RW-1:0] rn;
    logic                   ge;
    always_comb begin
      nx = dv_q[g];
      rn = '0;
      ge = 1'b0;
      for (int k = 0; k < 3; k++) begin
        rn = {dv_q[g].rem[k][ntn_pkg::RW-2:0], dv_q[g].nlow[k][ntn_pkg::QW-1]};
        ge = (rn >= ntn_pkg::RW'(dv_q[g].r));
        nx.rem[k]  = ge ? (rn - ntn_pkg::RW'(dv_q[g].r)) : rn;
        nx.nlow[k] = {dv_q[g].nlow[k][ntn_pkg::QW-2:0], 1'b0};
        nx.q[k]    = {dv_q[g].q[k][ntn_pkg::QW-2:0], ge};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[g+1] <= nx;
    end
  end

  // cap, sign, output register
  logic [2:0][15:0] res_c;
  logic [15:0]      qc;
  always_comb begin
    qc = '0;
    for (int k = 0; k < 3; k++) begin
      qc = (dv_q[ntn_pkg::QW].q[k] > ntn_pkg::QW'(ntn_pkg::CAP)) ?
           16'(ntn_pkg::CAP) : 16'(dv_q[ntn_pkg::QW].q[k]);
      res_c[k] = dv_q[ntn_pkg::QW].zero ? 16'd0 :
                 (dv_q[ntn_pkg::QW].neg[k] ? 16'(-qc) : qc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_x_q  <= res_c[0];
      unit_y_q  <= res_c[1];
      unit_z_q  <= res_c[2];
      zero_q    <= dv_q[ntn_pkg::QW].zero;
      fin_out_q <= dv_q[ntn_pkg::QW].fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign unit_x_o      = unit_x_q;
  assign unit_y_o      = unit_y_q;
  assign unit_z_o      = unit_z_q;
  assign zero_length_o = zero_q;
  assign final_out_o   = fin_out_q;

endmodule

// File: rtl/core/ntn_checker.sv
module ntn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] unit_x_o,
  input logic signed [15:0] unit_y_o,
  input logic signed [15:0] unit_z_o,
  input logic               zero_length_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> unit_x_o == 16'sd0 && unit_y_o == 16'sd0 &&
    unit_z_o == 16'sd0)
    else $error("zero vector with nonzero output");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> unit_x_o >= -16'sd16384 && unit_x_o <= 16'sd16384 &&
    unit_y_o >= -16'sd16384 && unit_y_o <= 16'sd16384 &&
    unit_z_o >= -16'sd16384 && unit_z_o <= 16'sd16384)
    else $error("component out of unit range");

  a_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_length_o |-> unit_x_o != 16'sd0 || unit_y_o != 16'sd0 ||
    unit_z_o != 16'sd0)
    else $error("nonzero vector normalised to zero");

endmodule

bind normal_transform_normalize ntn_checker u_ntn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .unit_x_o      (unit_x_o),
  .unit_y_o      (unit_y_o),
  .unit_z_o      (unit_z_o),
  .zero_length_o (zero_length_o)
);
